// ===== rtl/scps_pkg.sv =====
// shared types and constants for the steering command pi servo
`default_nettype none

package scps_pkg;

   // register widths
   localparam int unsigned GAIN_W  = 8;
   localparam int unsigned ILIM_W  = 14;
   localparam int unsigned DLIM_W  = 17;
   localparam int unsigned WDOG_W  = 8;

   // datapath widths
   localparam int unsigned POS_W   = 16;
   localparam int unsigned INTEG_W = 15;
   localparam int unsigned DUTY_W  = 18;

   // apb port
   localparam int unsigned CSR_AW  = 4;
   localparam int unsigned CSR_DW  = 32;

   // register reset values
   localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd80;
   localparam logic [ILIM_W-1:0] ILIM_RESET = 14'd2000;
   localparam logic [DLIM_W-1:0] DLIM_RESET = 17'd70000;
   localparam logic [WDOG_W-1:0] WDOG_RESET = 8'd20;

   // frame receiver constants
   localparam logic [7:0]  SYNC_BYTE  = 8'h55;
   localparam logic [15:0] SUM_SEED   = 16'd211;
   localparam logic [15:0] SUM_FACTOR = 16'd211;

   // setpoint = (angle + 10000) * 3 / 100 + 200, divide by 100 via reciprocal
   // 503319 = 3 * ceil(2^24 / 100), exact for products below 2^17
   localparam logic [16:0] SP_OFFSET   = 17'd10000;
   localparam logic [34:0] SP_RECIP    = 35'd503319;
   localparam int unsigned SP_SHIFT    = 24;
   localparam logic [15:0] SP_BASE     = 16'd200;
   localparam logic [15:0] SP_RESET    = 16'd512;
   localparam logic [WDOG_W-1:0] WDOG_COUNT_RESET = 8'd255;

   typedef enum logic [1:0] {
      REG_PROP_GAIN   = 2'd0,
      REG_INTEG_LIMIT = 2'd1,
      REG_DUTY_LIMIT  = 2'd2,
      REG_WDOG_TICKS  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] prop_gain;
      logic [ILIM_W-1:0] integ_limit;
      logic [DLIM_W-1:0] duty_limit;
      logic [WDOG_W-1:0] watchdog_ticks;
   } cfg_type;

   typedef struct packed {
      logic                    arm;
      logic signed [POS_W-1:0] setpoint;
   } frame_cmd_type;

   typedef struct packed {
      logic signed [DUTY_W-1:0] duty;
      logic                     engaged;
   } pi_result_type;

endpackage

`default_nettype wire

// ===== rtl/scps_csr.sv =====
// configuration registers behind the apb port
`default_nettype none

module scps_csr
   import scps_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready,
   output cfg_type                cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          write_en;

   assign index    = csr_index_type'(csr_paddr[3:2]);
   assign write_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_PROP_GAIN:   cfg_in.prop_gain      = csr_pwdata[GAIN_W-1:0];
            REG_INTEG_LIMIT: cfg_in.integ_limit    = csr_pwdata[ILIM_W-1:0];
            REG_DUTY_LIMIT:  cfg_in.duty_limit     = csr_pwdata[DLIM_W-1:0];
            REG_WDOG_TICKS:  cfg_in.watchdog_ticks = csr_pwdata[WDOG_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain      <= GAIN_RESET;
         cfg_ff.integ_limit    <= ILIM_RESET;
         cfg_ff.duty_limit     <= DLIM_RESET;
         cfg_ff.watchdog_ticks <= WDOG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (index)
         REG_PROP_GAIN:   csr_prdata = CSR_DW'(cfg_ff.prop_gain);
         REG_INTEG_LIMIT: csr_prdata = CSR_DW'(cfg_ff.integ_limit);
         REG_DUTY_LIMIT:  csr_prdata = CSR_DW'(cfg_ff.duty_limit);
         REG_WDOG_TICKS:  csr_prdata = CSR_DW'(cfg_ff.watchdog_ticks);
         default:         csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/scps_frame_rx.sv =====
// command frame receiver: sync hunt, payload collect, check byte, setpoint map
`default_nettype none

module scps_frame_rx
   import scps_pkg::*;
#(
   parameter int unsigned FRAME_BYTES = 4
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       byte_valid,
   input  wire logic [7:0] rx_byte,
   output frame_cmd_type   frame_cmd
);

   localparam int unsigned LEFT_W = $clog2(FRAME_BYTES + 1);

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_COLLECT = 2'd1,
      PH_CHECK   = 2'd2
   } phase_type;

   phase_type         phase_ff,    phase_in;
   logic [7:0]        prev_ff,     prev_in;
   logic [LEFT_W-1:0] left_ff,     left_in;
   logic [15:0]       sum_ff,      sum_in;
   logic [7:0]        ang_lo_ff,   ang_lo_in;
   logic [7:0]        ang_hi_ff,   ang_hi_in;
   logic [15:0]       setpoint_ff, setpoint_in;
   logic              arm;

   logic [15:0] byte_term;
   logic [15:0] sum_step;
   logic [16:0] sp_shifted;
   logic        sp_neg;
   logic [15:0] sp_mag;
   logic [34:0] sp_prod;
   logic [10:0] sp_quot;
   logic [15:0] sp_calc;

   // angle to setpoint, truncating toward zero
   always_comb begin
      sp_shifted = {ang_hi_ff[7], ang_hi_ff, ang_lo_ff} + SP_OFFSET;
      sp_neg     = sp_shifted[16];
      sp_mag     = sp_neg ? 16'(-sp_shifted) : sp_shifted[15:0];
      sp_prod    = {19'b0, sp_mag} * SP_RECIP;
      sp_quot    = sp_prod[SP_SHIFT +: 11];
      sp_calc    = sp_neg ? (SP_BASE - {5'b0, sp_quot}) : ({5'b0, sp_quot} + SP_BASE);
   end

   always_comb begin
      byte_term = {8'b0, rx_byte} * SUM_FACTOR;
      sum_step  = sum_ff + byte_term;
   end

   always_comb begin
      phase_in    = phase_ff;
      prev_in     = prev_ff;
      left_in     = left_ff;
      sum_in      = sum_ff;
      ang_lo_in   = ang_lo_ff;
      ang_hi_in   = ang_hi_ff;
      setpoint_in = setpoint_ff;
      arm         = 1'b0;
      if (byte_valid) begin
         prev_in = rx_byte;
         case (phase_ff)
            PH_COLLECT: begin
               left_in = left_ff - LEFT_W'(1);
               if (left_in == '0) begin
                  phase_in = PH_CHECK;
               end
               if (left_ff == LEFT_W'(FRAME_BYTES)) begin
                  ang_lo_in = rx_byte;
               end
               if (left_ff == LEFT_W'(FRAME_BYTES - 1)) begin
                  ang_hi_in = rx_byte;
               end
               sum_in = sum_step ^ {8'b0, sum_step[15:8]};
            end
            PH_CHECK: begin
               if (rx_byte == sum_ff[7:0]) begin
                  arm         = 1'b1;
                  setpoint_in = sp_calc;
               end
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
               if (rx_byte == SYNC_BYTE && prev_ff == SYNC_BYTE) begin
                  phase_in = PH_COLLECT;
                  sum_in   = SUM_SEED;
                  left_in  = LEFT_W'(FRAME_BYTES);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         prev_ff     <= '0;
         left_ff     <= '0;
         sum_ff      <= '0;
         ang_lo_ff   <= '0;
         ang_hi_ff   <= '0;
         setpoint_ff <= SP_RESET;
      end else begin
         phase_ff    <= phase_in;
         prev_ff     <= prev_in;
         left_ff     <= left_in;
         sum_ff      <= sum_in;
         ang_lo_ff   <= ang_lo_in;
         ang_hi_ff   <= ang_hi_in;
         setpoint_ff <= setpoint_in;
      end
   end

   assign frame_cmd.arm      = arm;
   assign frame_cmd.setpoint = $signed(setpoint_ff);

endmodule

`default_nettype wire

// ===== rtl/scps_pi_ctrl.sv =====
// watchdog and pi position step
`default_nettype none

module scps_pi_ctrl
   import scps_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    tick,
   input  wire logic signed [POS_W-1:0] sensor_position,
   input  wire cfg_type                 cfg,
   input  wire frame_cmd_type           frame_cmd,
   output pi_result_type                result
);

   logic [WDOG_W-1:0]         wd_ff,    wd_in;
   logic                      on_ff,    on_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;

   logic                      on_now;
   logic signed [POS_W-1:0]   err;
   logic signed [16:0]        isum;
   logic signed [16:0]        ilim;
   logic signed [16:0]        iclamp;
   logic signed [INTEG_W-1:0] integ_new;
   logic signed [24:0]        pterm;
   logic signed [INTEG_W-1:0] half_adj;
   logic signed [INTEG_W-1:0] half;
   logic signed [25:0]        dsum;
   logic signed [25:0]        dlim;
   logic signed [25:0]        dclamp;

   always_comb begin
      on_now = (wd_ff != '0) ? on_ff : 1'b0;
      err    = $signed(sensor_position - frame_cmd.setpoint);

      // integral clamp
      isum = $signed({integ_ff[INTEG_W-1], integ_ff[INTEG_W-1], integ_ff})
           + $signed({err[POS_W-1], err});
      ilim = $signed({3'b0, cfg.integ_limit});
      if (isum > ilim) begin
         iclamp = ilim;
      end else if (isum < -ilim) begin
         iclamp = -ilim;
      end else begin
         iclamp = isum;
      end
      integ_new = iclamp[INTEG_W-1:0];

      // proportional term plus half the integral, halving toward zero, clamped to the duty limit
      pterm    = err * $signed({1'b0, cfg.prop_gain});
      half_adj = integ_new + $signed({{(INTEG_W-1){1'b0}}, integ_new[INTEG_W-1]});
      half     = half_adj >>> 1;
      dsum     = pterm + half;
      dlim     = $signed({9'b0, cfg.duty_limit});
      if (dsum > dlim) begin
         dclamp = dlim;
      end else if (dsum < -dlim) begin
         dclamp = -dlim;
      end else begin
         dclamp = dsum;
      end
   end

   always_comb begin
      wd_in    = wd_ff;
      on_in    = on_ff;
      integ_in = integ_ff;
      if (frame_cmd.arm) begin
         wd_in = cfg.watchdog_ticks;
         on_in = 1'b1;
      end else if (tick) begin
         if (wd_ff != '0) begin
            wd_in = wd_ff - WDOG_W'(1);
         end else begin
            on_in = 1'b0;
         end
         integ_in = integ_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wd_ff    <= WDOG_COUNT_RESET;
         on_ff    <= 1'b0;
         integ_ff <= '0;
      end else begin
         wd_ff    <= wd_in;
         on_ff    <= on_in;
         integ_ff <= integ_in;
      end
   end

   assign result.duty    = on_now ? dclamp[DUTY_W-1:0] : '0;
   assign result.engaged = on_now;

endmodule

`default_nettype wire

// ===== rtl/steering_command_pi_servo.sv =====
// steering servo top level: request register, frame receiver, pi step, response register
// a tick request is held in the request register, then its result is loaded into the response register
// throughput: one request per cycle, stalled only while a response waits on rsp_ready
// the request register feeds one pass of logic that updates state and loads the response
// command byte requests update the frame receiver and produce no response
// reset (synchronous, active high) empties both registers, restarts the parser,
// clears the integral and control flag, loads the watchdog with 255 and setpoint with 512
`default_nettype none

module steering_command_pi_servo
   import scps_pkg::*;
#(
   parameter int unsigned FRAME_BYTES = 4
)
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_mode,
   input  wire logic [7:0]              req_rx_byte,
   input  wire logic signed [POS_W-1:0] req_sensor_position,
   // response channel
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [DUTY_W-1:0]     rsp_duty,
   output logic                         rsp_engaged,
   // configuration port
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CSR_AW-1:0]       csr_paddr,
   input  wire logic [CSR_DW-1:0]       csr_pwdata,
   output logic      [CSR_DW-1:0]       csr_prdata,
   output logic                         csr_pready
);

   // request register
   logic                    stage_valid_ff, stage_valid_in;
   logic                    stage_mode_ff;
   logic [7:0]              stage_byte_ff;
   logic signed [POS_W-1:0] stage_sensor_ff;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DUTY_W-1:0] rsp_duty_ff;
   logic                     rsp_engaged_ff;

   logic          out_free;
   logic          stage_fire;
   logic          req_take;
   cfg_type       cfg;
   frame_cmd_type frame_cmd;
   pi_result_type pi_result;

   // response slot is free when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_ready;
   // command bytes never wait; a tick waits for a free response slot
   assign stage_fire = stage_valid_ff && (!stage_mode_ff || out_free);
   assign req_ready  = !stage_valid_ff || stage_fire;
   assign req_take   = req_valid && req_ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_take) begin
         stage_valid_in = 1'b1;
      end else if (stage_fire) begin
         stage_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (stage_fire && stage_mode_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_mode_ff   <= req_mode;
         stage_byte_ff   <= req_rx_byte;
         stage_sensor_ff <= req_sensor_position;
      end
      if (stage_fire && stage_mode_ff) begin
         rsp_duty_ff    <= pi_result.duty;
         rsp_engaged_ff <= pi_result.engaged;
      end
   end

   scps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // frame receiver sees only command bytes as they leave the request register
   scps_frame_rx #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_frame_rx (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (stage_fire && !stage_mode_ff),
      .rx_byte    (stage_byte_ff),
      .frame_cmd  (frame_cmd)
   );

   // watchdog and pi step advance only on a tick that fires
   scps_pi_ctrl u_pi_ctrl (
      .clock           (clock),
      .reset           (reset),
      .tick            (stage_fire && stage_mode_ff),
      .sensor_position (stage_sensor_ff),
      .cfg             (cfg),
      .frame_cmd       (frame_cmd),
      .result          (pi_result)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_duty    = rsp_duty_ff;
   assign rsp_engaged = rsp_engaged_ff;

   // disengaged responses carry zero duty
   a_idle_duty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_engaged |-> rsp_duty == '0)
      else $error("disengaged response with nonzero duty");

   // a waiting response stays within the duty clamp
   a_duty_in_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_duty <= $signed({1'b0, cfg.duty_limit}))
                 && (rsp_duty >= -$signed({1'b0, cfg.duty_limit})))
      else $error("response duty outside clamp");

   // backpressure only comes from a tick blocked by a full response slot
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> stage_valid_ff && stage_mode_ff && rsp_valid_ff && !rsp_ready)
      else $error("request stalled without a blocked tick");

   // a blocked request stays held for the next cycle
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !stage_fire |=> stage_valid_ff && $stable(stage_sensor_ff))
      else $error("blocked request lost");

endmodule

`default_nettype wire

// ===== sim/servo_response_checker.sv =====
// request and response monitor with its own servo predictor and result comparison
`default_nettype none

module servo_response_checker
   import scps_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_ready,
   input  wire logic                    req_mode,
   input  wire logic [7:0]              req_rx_byte,
   input  wire logic signed [POS_W-1:0] req_sensor_position,
   input  wire logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire logic signed [DUTY_W-1:0] rsp_duty,
   input  wire logic                    rsp_engaged,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CSR_AW-1:0]       csr_paddr,
   input  wire logic [CSR_DW-1:0]       csr_pwdata,
   input  wire logic                    csr_pready,
   output int                           failures,
   output int                           ticks_pending
);

   localparam int FRAME_LEN = 4;

   typedef enum logic [1:0] {
      HUNT    = 2'd0,
      PAYLOAD = 2'd1,
      CHECK   = 2'd2
   } rx_phase_type;

   // register copy
   logic [GAIN_W-1:0] kp;
   logic [ILIM_W-1:0] ilim;
   logic [DLIM_W-1:0] dlim;
   logic [WDOG_W-1:0] wd_ticks;

   // frame receiver and loop state
   rx_phase_type      rx_phase;
   logic [7:0]        last_byte;
   logic [2:0]        remaining;
   logic [15:0]       run_sum;
   logic [7:0]        payload [FRAME_LEN];
   int                target;
   int                integ;
   logic [WDOG_W-1:0] wdog;
   logic              engaged_q;

   pi_result_type     duty_expected_q [$];
   pi_result_type     want;
   logic [7:0]        b;
   int                diff;
   int                err_v;
   int                duty_v;
   int                angle;

   function automatic int clamp_symmetric(input int v, input int lim);
      if (v < -lim) return -lim;
      if (v > lim) return lim;
      return v;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         kp        = GAIN_RESET;
         ilim      = ILIM_RESET;
         dlim      = DLIM_RESET;
         wd_ticks  = WDOG_RESET;
         rx_phase  = HUNT;
         last_byte = 8'd0;
         remaining = 3'd0;
         run_sum   = 16'd0;
         for (int i = 0; i < FRAME_LEN; i++) payload[i] = 8'd0;
         target    = int'($signed(SP_RESET));
         integ     = 0;
         wdog      = WDOG_COUNT_RESET;
         engaged_q = 1'b0;
         failures  = 0;
         duty_expected_q.delete();
      end else begin
         // compare against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (duty_expected_q.size() == 0) begin
               $error("response with no tick pending: duty %0d engaged %0d",
                      rsp_duty, rsp_engaged);
               failures++;
            end else begin
               want = duty_expected_q.pop_front();
               if (rsp_duty !== want.duty) begin
                  $error("duty: expected %0d, got %0d", want.duty, rsp_duty);
                  failures++;
               end
               if (rsp_engaged !== want.engaged) begin
                  $error("engaged: expected %0d, got %0d", want.engaged, rsp_engaged);
                  failures++;
               end
            end
         end

         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[CSR_AW-1:2]))
               REG_PROP_GAIN:   kp       = csr_pwdata[GAIN_W-1:0];
               REG_INTEG_LIMIT: ilim     = csr_pwdata[ILIM_W-1:0];
               REG_DUTY_LIMIT:  dlim     = csr_pwdata[DLIM_W-1:0];
               REG_WDOG_TICKS:  wd_ticks = csr_pwdata[WDOG_W-1:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            if (req_mode) begin
               // control tick
               if (wdog != '0) wdog = wdog - 1'b1;
               else engaged_q = 1'b0;
               diff   = int'(req_sensor_position) - target;
               err_v  = int'($signed(diff[15:0]));
               integ  = clamp_symmetric(integ + err_v, int'(ilim));
               duty_v = engaged_q ?
                        clamp_symmetric(err_v * int'(kp) + integ / 2, int'(dlim)) : 0;
               want.duty    = duty_v[DUTY_W-1:0];
               want.engaged = engaged_q;
               duty_expected_q.push_back(want);
            end else begin
               // command byte
               b = req_rx_byte;
               case (rx_phase)
                  PAYLOAD: begin
                     remaining = remaining - 3'd1;
                     if (remaining == 3'd0) rx_phase = CHECK;
                     payload[(FRAME_LEN - 1 - int'(remaining)) % FRAME_LEN] = b;
                     run_sum = run_sum + 16'(b * SUM_FACTOR);
                     run_sum = run_sum ^ (run_sum >> 8);
                  end
                  CHECK: begin
                     if (b == run_sum[7:0]) begin
                        angle     = int'($signed({payload[1], payload[0]}));
                        wdog      = wd_ticks;
                        engaged_q = 1'b1;
                        target    = (angle + int'(SP_OFFSET)) * 600 / 20000 + int'(SP_BASE);
                     end
                     rx_phase = HUNT;
                  end
                  default: begin
                     rx_phase = HUNT;
                     if (b == SYNC_BYTE && last_byte == SYNC_BYTE) begin
                        rx_phase  = PAYLOAD;
                        run_sum   = SUM_SEED;
                        remaining = 3'(FRAME_LEN);
                     end
                  end
               endcase
               last_byte = b;
            end
         end
      end
      ticks_pending = duty_expected_q.size();
   end

endmodule

`default_nettype wire

// ===== sim/steering_command_pi_servo_tb.sv =====
// testbench top for the steering command pi servo: stimulus, clock, reset and verdict
`default_nettype none

module steering_command_pi_servo_tb
   import scps_pkg::*;
();

   // request kinds
   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // window of requests sent with no idling on either side
   localparam int QUIET_FROM = 800;
   localparam int QUIET_TO   = 1100;

   // receiver hold-off length in cycles
   localparam int HOLD_CYCLES = 400;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic                     req_mode;
   logic [7:0]               req_rx_byte;
   logic signed [POS_W-1:0]  req_sensor_position;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [DUTY_W-1:0] rsp_duty;
   logic                     rsp_engaged;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_AW-1:0]        csr_paddr;
   logic [CSR_DW-1:0]        csr_pwdata;
   logic [CSR_DW-1:0]        csr_prdata;
   logic                     csr_pready;

   int   failures;
   int   ticks_pending;

   // sender bookkeeping, shared with the receiver process
   int         items_sent = 0;
   bit         quiet = 1'b0;
   bit         hold_go = 1'b0;
   bit         hold_done = 1'b0;
   logic [7:0] wdog_setting = WDOG_RESET;

   always #5 clock = ~clock;

   steering_command_pi_servo dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_rx_byte         (req_rx_byte),
      .req_sensor_position (req_sensor_position),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_duty            (rsp_duty),
      .rsp_engaged         (rsp_engaged),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   servo_response_checker checker_i (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_rx_byte         (req_rx_byte),
      .req_sensor_position (req_sensor_position),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_duty            (rsp_duty),
      .rsp_engaged         (rsp_engaged),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_pready          (csr_pready),
      .failures            (failures),
      .ticks_pending       (ticks_pending)
   );

   // check byte of a well-formed frame: seeded sum, add byte times factor, fold high byte
   function automatic logic [7:0] frame_checksum(input logic [7:0] p0, input logic [7:0] p1,
                                                 input logic [7:0] p2, input logic [7:0] p3);
      logic [15:0] s;
      logic [7:0]  pb [4];
      pb[0] = p0;
      pb[1] = p1;
      pb[2] = p2;
      pb[3] = p3;
      s = SUM_SEED;
      for (int i = 0; i < 4; i++) begin
         s = s + 16'(pb[i] * SUM_FACTOR);
         s = s ^ (s >> 8);
      end
      return s[7:0];
   endfunction

   // sensor sample: mostly near the reachable setpoint range, sometimes anywhere or extreme
   function automatic logic signed [POS_W-1:0] pick_position();
      int sel;
      sel = $urandom_range(0, 7);
      if (sel == 0) return ($urandom_range(0, 1) == 0) ? 16'sh8000 : 16'sh7fff;
      if (sel < 3) return POS_W'($urandom);
      return POS_W'($urandom_range(0, 2000) - 500);
   endfunction

   // one request: optional idle cycles, then hold valid until accepted
   // valid is never dropped between back-to-back requests
   task automatic send_req(input logic mode, input logic [7:0] rx,
                           input logic signed [POS_W-1:0] pos);
      quiet = (items_sent >= QUIET_FROM && items_sent < QUIET_TO);
      while (!quiet && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_mode            <= mode;
      req_rx_byte         <= rx;
      req_sensor_position <= pos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // unused payload field gets random content so every bit moves
   task automatic send_byte(input logic [7:0] rx);
      send_req(MODE_BYTE, rx, POS_W'($urandom));
   endtask

   task automatic send_tick(input logic signed [POS_W-1:0] pos);
      send_req(MODE_TICK, 8'($urandom), pos);
   endtask

   // sync pair, little-endian angle, two more payload bytes, check byte good or corrupted
   task automatic send_frame(input logic [15:0] angle, input logic [7:0] p2,
                             input logic [7:0] p3, input bit good);
      logic [7:0] chk;
      chk = frame_checksum(angle[7:0], angle[15:8], p2, p3);
      if (!good) chk = chk ^ 8'($urandom_range(1, 255));
      send_byte(SYNC_BYTE);
      send_byte(SYNC_BYTE);
      send_byte(angle[7:0]);
      send_byte(angle[15:8]);
      send_byte(p2);
      send_byte(p3);
      send_byte(chk);
   endtask

   // stop offering, let every tick response arrive, then cover the command byte latency
   task automatic drain_results;
      req_valid <= 1'b0;
      @(negedge clock);
      while (ticks_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // apb write: setup phase, access phase, then back to idle
   task automatic csr_write(input csr_index_type idx, input logic [CSR_DW-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // new register setting, only with the block idle
   task automatic configure(input logic [CSR_DW-1:0] gain, input logic [CSR_DW-1:0] ilim,
                            input logic [CSR_DW-1:0] dlim, input logic [CSR_DW-1:0] wd);
      drain_results;
      csr_write(REG_PROP_GAIN, gain);
      csr_write(REG_INTEG_LIMIT, ilim);
      csr_write(REG_DUTY_LIMIT, dlim);
      csr_write(REG_WDOG_TICKS, wd);
      wdog_setting = wd[7:0];
   endtask

   // random traffic: mostly good frames followed by tick runs, plus noise and broken frames
   task automatic random_phase(input int n_items);
      int         stop_at;
      int         kind;
      int         run;
      logic [15:0] angle;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            if ($urandom_range(0, 3) == 0) send_byte(8'($urandom));
            case ($urandom_range(0, 7))
               0:       angle = 16'h8000;
               1:       angle = 16'h7fff;
               2:       angle = 16'h0000;
               default: angle = 16'($urandom);
            endcase
            send_frame(angle, 8'($urandom), 8'($urandom), $urandom_range(0, 99) < 85);
            // some runs outlast the watchdog so control drops mid-run
            run = ($urandom_range(0, 7) == 0) ? int'(wdog_setting) + 3 : $urandom_range(1, 30);
            if (!hold_done && items_sent > 400) begin
               // receiver stalls while ticks keep coming, the block backs up
               hold_go   = 1'b1;
               hold_done = 1'b1;
               run       = 60;
            end
            repeat (run) begin
               if ($urandom_range(0, 9) == 0) send_byte(8'($urandom));
               send_tick(pick_position());
            end
         end else if (kind < 85) begin
            // noise biased toward the sync byte, runs of three or more included
            repeat ($urandom_range(1, 6))
               send_byte(($urandom_range(0, 99) < 35) ? SYNC_BYTE : 8'($urandom));
         end else if (kind < 93) begin
            // truncated frame, whatever follows lands in the payload
            send_byte(SYNC_BYTE);
            send_byte(SYNC_BYTE);
            repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
         end else begin
            repeat ($urandom_range(1, 8)) send_tick(pick_position());
         end
      end
   endtask

   // receiver: random stalls, a long hold-off on request, none in the quiet window
   initial begin : receiver
      int hold_left;
      rsp_ready = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_go) begin
            hold_go   = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < 7) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // run limit, far above the slowest legal run
   initial begin
      #5000000;
      $display("steering_command_pi_servo_tb failed");
      $finish;
   end

   initial begin : stimulus
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_mode            = MODE_BYTE;
      req_rx_byte         = 8'd0;
      req_sensor_position = '0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values written back explicitly
      configure(32'(GAIN_RESET), 32'(ILIM_RESET), 32'(DLIM_RESET), 32'(WDOG_RESET));

      // directed: ticks before any frame are disengaged, position extremes
      send_tick(16'sh0000);
      send_tick(16'sh8000);
      send_tick(16'sh7fff);
      // most negative angle, good check byte, then saturating errors both ways
      send_frame(16'h8000, 8'h00, 8'hff, 1'b1);
      send_tick(16'sh7fff);
      send_tick(16'sh8000);
      // most positive angle with a bad check byte, frame dropped
      send_frame(16'h7fff, 8'hff, 8'h00, 1'b0);
      send_tick(16'sh0000);

      random_phase(250);

      // upper extremes, watchdog at its longest
      configure(32'd255, 32'd16383, 32'd131071, 32'd255);
      random_phase(250);

      // lower extremes, watchdog of zero drops control on the first tick
      configure(32'd0, 32'd0, 32'd0, 32'd0);
      random_phase(200);

      configure(32'd1, 32'd1, 32'd1, 32'd1);
      random_phase(200);

      // full-width garbage, only the register width is kept
      configure($urandom, $urandom, $urandom, $urandom);
      random_phase(250);

      configure($urandom_range(1, 255), $urandom_range(0, 16383),
                $urandom_range(0, 131071), $urandom_range(1, 255));
      random_phase(250);

      drain_results;
      repeat (8) @(negedge clock);
      if (failures == 0) begin
         $display("steering_command_pi_servo_tb passed");
      end else begin
         $display("steering_command_pi_servo_tb failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/scps_pkg.sv
rtl/scps_csr.sv
rtl/scps_frame_rx.sv
rtl/scps_pi_ctrl.sv
rtl/steering_command_pi_servo.sv
sim/servo_response_checker.sv
sim/steering_command_pi_servo_tb.sv
